FILE: rtl/wwh_pkg.sv
// Shared types and constants for the window word histogram.
package wwh_pkg;
    localparam int unsigned FRAC_W = 17;
    localparam int unsigned CNT_W  = 10;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REG_HALF_HEIGHT  = 2'd0,
        REG_HALF_WIDTH   = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_IMAGE_WIDTH  = 2'd3
    } t_reg;
endpackage

FILE: rtl/wwh_divider.sv
// Restoring divider: floor(count*65536/area), one quotient bit per cycle.
module wwh_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wwh_pkg::CNT_W-1:0]   i_num,
    input  logic [wwh_pkg::CNT_W-1:0]   i_den,
    output logic                        o_done,
    output logic [wwh_pkg::FRAC_W-1:0]  o_quo
);
    localparam int unsigned NW = wwh_pkg::CNT_W + 16;
    logic [NW-1:0]             r_num, n_num;
    logic [wwh_pkg::CNT_W:0]   r_rem, n_rem;
    logic [NW-1:0]             r_quo, n_quo;
    logic [4:0]                r_cnt, n_cnt;
    logic                      r_busy, n_busy, r_done, n_done;
    logic [wwh_pkg::CNT_W+1:0] trial;

    always_comb begin
        n_num = r_num; n_rem = r_rem; n_quo = r_quo;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        trial = {r_rem, r_num[NW-1]} - {2'b00, i_den};
        if (i_start) begin
            n_num = {i_num, 16'd0}; n_rem = '0; n_quo = '0;
            n_cnt = 5'(NW); n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NW-2:0], 1'b0};
            if (!trial[wwh_pkg::CNT_W+1]) begin
                n_rem = trial[wwh_pkg::CNT_W:0];
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[wwh_pkg::CNT_W-1:0], r_num[NW-1]};
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num; r_rem <= n_rem; r_quo <= n_quo;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
    end

    assign o_done = r_done;
    assign o_quo  = (i_den == '0) ? '0 : r_quo[wwh_pkg::FRAC_W-1:0];
endmodule

FILE: rtl/window_word_histogram.sv
// Top level: sliding-window visual word histogram with bin counters and a single shared divider.
// Usage: a load (kind 0) is written when accepted and gives no result. A query
// (kind 1) scans the window one pixel per cycle through the single read port of
// the word store, adding into the bin counters through a short read-modify-write
// pipeline (one increment per cycle, back-to-back hits on one bin forwarded),
// then walks the bins: for each bin one counter read and a restoring division
// give one strobed result, and the counter is cleared once reported. The
// default window holds 121 pixels. Results come with o_valid for one cycle each
// and cannot be stalled; the last bin has o_last. After reset the bin counters
// are cleared by a pass over every bin, during which busy is high. The word
// store is not cleared.
module window_word_histogram #(
    parameter int unsigned MAX_WIDTH       = 256,
    parameter int unsigned MAX_HEIGHT      = 256,
    parameter int unsigned NUM_BINS        = 50,
    parameter int unsigned MAX_HALF_WINDOW = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [0:0]  i_kind,
    input  logic [7:0]  i_col,
    input  logic [7:0]  i_row,
    input  logic [15:0] i_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    output logic        o_valid,
    output logic [5:0]  o_bin,
    output logic [9:0]  o_count,
    output logic [9:0]  o_area,
    output logic [16:0] o_fraction,
    output logic        o_last
);
    localparam int unsigned XW = $clog2(MAX_WIDTH);
    localparam int unsigned YW = $clog2(MAX_HEIGHT);
    localparam int unsigned BW = $clog2(NUM_BINS + 1);
    localparam int unsigned CW = 14;   // signed coordinate work width
    localparam logic [5:0] NO_BIN = 6'd63;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_BIN   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [3:0] r_hh, r_hw;
    logic [8:0] r_ih, r_iw;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hh <= 4'd5; r_hw <= 4'd5; r_ih <= 9'd256; r_iw <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (wwh_pkg::t_reg'(i_cfg_index))
                wwh_pkg::REG_HALF_HEIGHT:  r_hh <= i_cfg_data[3:0];
                wwh_pkg::REG_HALF_WIDTH:   r_hw <= i_cfg_data[3:0];
                wwh_pkg::REG_IMAGE_HEIGHT: r_ih <= i_cfg_data;
                wwh_pkg::REG_IMAGE_WIDTH:  r_iw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped config
    logic signed [CW-1:0] h, w, hmax, wmax;
    always_comb begin
        h = (r_hh > MAX_HALF_WINDOW) ? CW'(MAX_HALF_WINDOW) : CW'(r_hh);
        w = (r_hw > MAX_HALF_WINDOW) ? CW'(MAX_HALF_WINDOW) : CW'(r_hw);
        hmax = (r_ih == 9'd0) ? CW'(0) :
               (r_ih > MAX_HEIGHT) ? CW'(MAX_HEIGHT - 1) : CW'(r_ih) - CW'(1);
        wmax = (r_iw == 9'd0) ? CW'(0) :
               (r_iw > MAX_WIDTH) ? CW'(MAX_WIDTH - 1) : CW'(r_iw) - CW'(1);
    end

    // word store
    logic [5:0] mem [MAX_WIDTH*MAX_HEIGHT];
    logic [5:0] r_rd;
    logic       accept;
    assign accept = start && !busy;
    logic [YW-1:0] rd_y;
    logic [XW-1:0] rd_x;
    always_ff @(posedge i_clk) begin
        if (accept && i_kind == wwh_pkg::KIND_LOAD && 32'(i_col) < MAX_WIDTH
            && 32'(i_row) < MAX_HEIGHT)
            mem[{YW'(i_row), XW'(i_col)}] <=
                (32'(i_word) < NUM_BINS) ? 6'(i_word) : NO_BIN;
        r_rd <= mem[{rd_y, rd_x}];
    end

    // window bounds
    logic signed [CW-1:0] r_bot, r_left, r_right;
    logic signed [CW-1:0] r_y, r_x;
    logic [9:0]           r_area;
    logic                 r_rdv, n_rdv;
    logic                 r_scan_end, n_scan_end;
    logic [7:0]           r_qrow, r_qcol;

    assign rd_y = YW'(r_y);
    assign rd_x = XW'(r_x);

    logic signed [CW-1:0] t_top, t_bot, t_left, t_right, nr, nc;
    always_comb begin
        t_top   = CW'(r_qrow) - h - CW'(1);
        if (t_top < 0) t_top = '0;
        t_bot   = CW'(r_qrow) + h;
        if (t_bot > hmax) t_bot = hmax;
        t_left  = CW'(r_qcol) - w - CW'(1);
        if (t_left < 0) t_left = '0;
        t_right = CW'(r_qcol) + w;
        if (t_right > wmax) t_right = wmax;
        nr = (t_bot > t_top) ? t_bot - t_top : '0;
        nc = (t_right > t_left) ? t_right - t_left : '0;
    end

    // bin counters
    logic [9:0]    cnt [NUM_BINS];
    logic [BW-1:0] r_bi;
    logic [BW-1:0] cv_addr;
    logic [9:0]    r_cv;
    logic          div_start, div_done;
    logic [16:0]   dq;

    // increment pipeline: read counter, then write it back plus one
    logic          r_iv, r_wv;
    logic [BW-1:0] r_ibin, r_wbin;
    logic [9:0]    r_cread, r_wval;
    logic [9:0]    cnt_inc;

    assign cnt_inc = ((r_wv && r_wbin == r_ibin) ? r_wval : r_cread) + 10'd1;

    // next bin is fetched while the current one is on the outputs
    always_comb begin
        cv_addr = r_bi;
        if (r_state == S_OUT)
            cv_addr = (32'(r_bi) == NUM_BINS - 1) ? '0 : r_bi + BW'(1);
    end

    wwh_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_cv), .i_den(r_area), .o_done(div_done), .o_quo(dq)
    );

    always_comb begin
        n_state = r_state;
        n_rdv = 1'b0;
        n_scan_end = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            S_CLEAR: if (32'(r_bi) == NUM_BINS - 1) n_state = S_IDLE;
            S_IDLE:  if (accept && i_kind == wwh_pkg::KIND_QUERY) n_state = S_SETUP;
            S_SETUP: n_state = (nr > 0 && nc > 0) ? S_SCAN : S_BIN;
            S_SCAN: begin
                n_rdv = !r_scan_end;
                if (!r_scan_end && r_y == r_bot && r_x == r_right) begin
                    n_scan_end = 1'b1;
                end else if (r_scan_end) begin
                    // wait for the last read and the last write-back
                    if (!r_rdv && !r_iv) n_state = S_BIN;
                    else n_scan_end = 1'b1;
                end
            end
            S_BIN: begin div_start = 1'b1; n_state = S_DIV; end
            S_DIV:   if (div_done) n_state = S_OUT;
            S_OUT:   n_state = (32'(r_bi) == NUM_BINS - 1) ? S_IDLE : S_BIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_bi <= '0; r_rdv <= 1'b0; r_scan_end <= 1'b0;
            r_iv <= 1'b0; r_wv <= 1'b0;
        end else begin
            r_state <= n_state; r_rdv <= n_rdv; r_scan_end <= n_scan_end;
            r_iv <= r_rdv && (32'(r_rd) < NUM_BINS);
            r_wv <= r_iv;
            unique case (r_state)
                S_CLEAR: begin
                    cnt[r_bi] <= '0;
                    r_bi <= (32'(r_bi) == NUM_BINS - 1) ? '0 : r_bi + BW'(1);
                end
                S_IDLE: if (accept) begin r_qrow <= i_row; r_qcol <= i_col; end
                S_SETUP: begin
                    r_bot <= t_bot; r_left <= t_left; r_right <= t_right;
                    r_y <= t_top + CW'(1); r_x <= t_left + CW'(1);
                    r_area <= 10'(nr * nc);
                    r_bi <= '0;
                end
                S_SCAN: begin
                    if (!r_scan_end) begin
                        if (r_x == r_right) begin
                            r_x <= r_left + CW'(1); r_y <= r_y + CW'(1);
                        end else r_x <= r_x + CW'(1);
                    end
                    if (r_iv) cnt[r_ibin] <= cnt_inc;
                end
                S_OUT: begin
                    cnt[r_bi] <= '0;   // ready for the next query
                    r_bi <= (32'(r_bi) == NUM_BINS - 1) ? '0 : r_bi + BW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cv    <= cnt[cv_addr];
        r_cread <= cnt[r_rd[BW-1:0]];
        r_ibin  <= r_rd[BW-1:0];
        r_wbin  <= r_ibin;
        r_wval  <= cnt_inc;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_bin      = 6'(r_bi);
    assign o_count    = r_cv;
    assign o_area     = r_area;
    assign o_fraction = dq;
    assign o_last     = (r_state == S_OUT) && (32'(r_bi) == NUM_BINS - 1);

    // checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> busy) else $error("scan while not busy");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> r_state == S_IDLE) else $error("last did not end query");
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_DIV) else $error("result without divide");
endmodule
